### rtl/core/lps_pkg.sv
// Shared types and widths for the line point solver.
// Used by every module in rtl/core; depends on nothing.
package lps_pkg;

	localparam int CW = 16;
	localparam int DW = CW + 1;
	localparam int PW = CW + DW;
	localparam int SW = 2 * CW + 2;
	localparam int NW = 2 * CW + 1;
	localparam int NCELL = NW;

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
		logic signed [CW-1:0] search_x;
		logic signed [CW-1:0] search_y;
		logic                 command;
	} query_t;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic          use_div;
		logic          solve_y;
		logic [CW-1:0] px;
		logic [CW-1:0] py;
	} side_t;

	typedef struct packed {
		logic [NW-1:0] num;
		logic [CW-1:0] dm;
		logic [CW-1:0] rem;
		logic [CW-1:0] quo;
		logic          neg;
		side_t         side;
	} div_t;

endpackage

### rtl/core/line_point_solver_unit.sv
// Line point solver: front stages, a chain of divider cells, rounding and output buffer.
// Stages: four front stages, one divider cell per numerator bit
// and the output register. One transfer is taken per cycle; the pipeline stalls only while
// the skid entry holds a result. Reset clears all valid bits; the data path is not reset.
// Depends on lps_pkg, lps_front and lps_div_cell.
module line_point_solver_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            query_valid,
	output logic            query_ready,
	input  lps_pkg::query_t query,
	output logic            point_valid,
	input  logic            point_ready,
	output lps_pkg::point_t point
);

	logic                en;
	logic                cell_valid [lps_pkg::NCELL+1];
	lps_pkg::div_t       cell_div   [lps_pkg::NCELL+1];
	lps_pkg::div_t       last;
	logic                half;
	logic [lps_pkg::CW-1:0] base, res;
	lps_pkg::point_t     result;
	logic                push;
	logic                skid_valid_q;
	lps_pkg::point_t     skid_q;
	lps_pkg::point_t     point_q;
	logic                point_valid_q;

	assign en = ~skid_valid_q;
	assign query_ready = en;

	lps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.query_valid(query_valid),
		.query      (query),
		.down_valid (cell_valid[0]),
		.down       (cell_div[0])
	);

	for (genvar i = 0; i < lps_pkg::NCELL; i++) begin : g_cell
		lps_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.up_valid  (cell_valid[i]),
			.up        (cell_div[i]),
			.down_valid(cell_valid[i+1]),
			.down      (cell_div[i+1])
		);
	end

	always_comb begin
		last = cell_div[lps_pkg::NCELL];
		half = {last.rem, 1'b0} >= {1'b0, last.dm};
		base = last.neg ? ~last.quo : last.quo;
		res = base + {{(lps_pkg::CW-1){1'b0}}, last.neg ^ half};
		result.point_x = last.side.px;
		result.point_y = last.side.py;
		if (last.side.use_div) begin
			if (last.side.solve_y) begin
				result.point_y = res;
			end else begin
				result.point_x = res;
			end
		end
	end

	assign push = en & cell_valid[lps_pkg::NCELL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!point_valid_q || point_ready) begin
			if (skid_valid_q) begin
				point_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				point_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!point_valid_q || point_ready) begin
			point_q <= skid_valid_q ? skid_q : result;
		end else if (push) begin
			skid_q <= result;
		end
	end

	assign point_valid = point_valid_q;
	assign point = point_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> point_valid_q)
		else $error("Skid entry holds a result while the output register is empty.");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(point_valid_q && !point_ready))
		else $error("Skid entry filled without a stalled output transfer.");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && point_ready |=> !skid_valid_q && point_valid_q)
		else $error("Skid entry did not move to the output register.");

endmodule

### rtl/core/lps_front.sv
// Front stages: differences, the two products, their sum and its magnitude.
// Also resolves the vertical and horizontal line cases. Depends on lps_pkg.
module lps_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           query_valid,
	input  lps_pkg::query_t query,
	output logic           down_valid,
	output lps_pkg::div_t  down
);

	lps_pkg::query_t q_s1;
	logic signed [lps_pkg::DW-1:0] dx_s1, dy_s1, dq_s1;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [lps_pkg::PW-1:0] p1_s2;
	logic signed [lps_pkg::SW-1:0] p2_s2;
	logic                          den_neg_s2;
	logic [lps_pkg::CW-1:0]        dm_s2;
	lps_pkg::side_t                side_s2;

	logic signed [lps_pkg::SW-1:0] sum_s3;
	logic                          den_neg_s3;
	logic [lps_pkg::CW-1:0]        dm_s3;
	lps_pkg::side_t                side_s3;

	lps_pkg::div_t div_s4;

	logic signed [lps_pkg::DW-1:0] dx, dy, dq;
	logic signed [lps_pkg::CW-1:0] op_a;
	logic signed [lps_pkg::DW-1:0] op_b, op_d;
	logic [lps_pkg::DW-1:0]        b_abs;
	logic [lps_pkg::DW-1:0]        msum_x, msum_y, mid_x, mid_y;
	lps_pkg::side_t                side;
	logic [lps_pkg::SW-1:0]        sum_abs;
	lps_pkg::div_t                 div;

	always_comb begin
		dx = {query.end_x[lps_pkg::CW-1], query.end_x}
			- {query.start_x[lps_pkg::CW-1], query.start_x};
		dy = {query.end_y[lps_pkg::CW-1], query.end_y}
			- {query.start_y[lps_pkg::CW-1], query.start_y};
		if (query.command) begin
			dq = {query.search_x[lps_pkg::CW-1], query.search_x}
				- {query.start_x[lps_pkg::CW-1], query.start_x};
		end else begin
			dq = {query.search_y[lps_pkg::CW-1], query.search_y}
				- {query.start_y[lps_pkg::CW-1], query.start_y};
		end
	end

	always_comb begin
		op_a = q_s1.command ? q_s1.start_y : q_s1.start_x;
		op_b = q_s1.command ? dx_s1 : dy_s1;
		op_d = q_s1.command ? dy_s1 : dx_s1;
		b_abs = op_b[lps_pkg::DW-1] ? (~op_b + 1'b1) : op_b;

		msum_x = {q_s1.start_x[lps_pkg::CW-1], q_s1.start_x}
			+ {q_s1.end_x[lps_pkg::CW-1], q_s1.end_x};
		msum_y = {q_s1.start_y[lps_pkg::CW-1], q_s1.start_y}
			+ {q_s1.end_y[lps_pkg::CW-1], q_s1.end_y};
		mid_x = msum_x + {{(lps_pkg::DW-1){1'b0}}, msum_x[lps_pkg::DW-1]};
		mid_y = msum_y + {{(lps_pkg::DW-1){1'b0}}, msum_y[lps_pkg::DW-1]};

		side.use_div = 1'b0;
		side.solve_y = q_s1.command;
		side.px = q_s1.search_x;
		side.py = q_s1.search_y;
		if (dx_s1 == '0) begin
			if (q_s1.command) begin
				side.py = mid_y[lps_pkg::DW-1:1];
			end else begin
				side.px = q_s1.start_x;
			end
		end else if (dy_s1 == '0) begin
			side.py = q_s1.start_y;
			if (!q_s1.command) begin
				side.px = mid_x[lps_pkg::DW-1:1];
			end
		end else begin
			side.use_div = 1'b1;
		end
	end

	always_comb begin
		sum_abs = sum_s3[lps_pkg::SW-1] ? (~sum_s3 + 1'b1) : sum_s3;
		div.num = sum_abs[lps_pkg::NW-1:0];
		div.dm = dm_s3;
		div.rem = '0;
		div.quo = '0;
		div.neg = sum_s3[lps_pkg::SW-1] ^ den_neg_s3;
		div.side = side_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= query_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= query;
			dx_s1 <= dx;
			dy_s1 <= dy;
			dq_s1 <= dq;

			p1_s2 <= op_a * op_b;
			p2_s2 <= dq_s1 * op_d;
			den_neg_s2 <= op_b[lps_pkg::DW-1];
			dm_s2 <= b_abs[lps_pkg::CW-1:0];
			side_s2 <= side;

			sum_s3 <= lps_pkg::SW'(p1_s2) + p2_s2;
			den_neg_s3 <= den_neg_s2;
			dm_s3 <= dm_s2;
			side_s3 <= side_s2;

			div_s4 <= div;
		end
	end

	assign down_valid = v_s4;
	assign down = div_s4;

endmodule

### rtl/core/lps_div_cell.sv
// One cell of the divider chain: settles one quotient bit per stage.
// Depends on lps_pkg.
module lps_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          up_valid,
	input  lps_pkg::div_t up,
	output logic          down_valid,
	output lps_pkg::div_t down
);

	logic [lps_pkg::CW:0] trial, diff;
	logic                 fit;
	lps_pkg::div_t        nxt;
	logic                 valid_q;
	lps_pkg::div_t        data_q;

	always_comb begin
		trial = {up.rem, up.num[lps_pkg::NW-1]};
		fit = trial >= {1'b0, up.dm};
		diff = trial - {1'b0, up.dm};
		nxt = up;
		nxt.num = {up.num[lps_pkg::NW-2:0], 1'b0};
		nxt.rem = fit ? diff[lps_pkg::CW-1:0] : trial[lps_pkg::CW-1:0];
		nxt.quo = {up.quo[lps_pkg::CW-2:0], fit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign down_valid = valid_q;
	assign down = data_q;

endmodule
